/* rtl/sef_pkg.sv */
// Shared types and constants for the silhouette edge finder.
package sef_pkg;

   // Command codes carried on req_op.
   typedef enum logic [1:0] {
      OP_BEGIN    = 2'd0,
      OP_VERTEX   = 2'd1,
      OP_TRIANGLE = 2'd2,
      OP_FETCH    = 2'd3
   } op_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_LIGHT_X      = 2'd0;
   localparam logic [1:0] CSR_LIGHT_Y      = 2'd1;
   localparam logic [1:0] CSR_LIGHT_Z      = 2'd2;
   localparam logic [1:0] CSR_VERTEX_COUNT = 2'd3;

   // Fixed field widths.
   localparam int COORD_W = 16;
   localparam int INDEX_W = 10;
   localparam int DIFF_W  = 17;
   localparam int NORM_W  = 35;
   localparam int PROD_W  = 52;
   localparam int ACC_W   = 54;

   // Multiply steps: six for the cross product, three for the dot product.
   localparam logic [3:0] LAST_STEP = 4'd8;
   localparam logic [3:0] DOT_STEP  = 4'd6;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_VRD_B,
      ST_VRD_C,
      ST_VCAP_C,
      ST_MUL,
      ST_ACC,
      ST_ECNT_RD,
      ST_ECNT_WR,
      ST_WCHK,
      ST_WCNT,
      ST_WSLOT,
      ST_RCNT,
      ST_RSCAN
   } state_type;

endpackage

/* rtl/silhouette_edge_finder.sv */
// Silhouette edge finder: vertex and edge tables, facing test and edge walk.
// Load vertex stays idle; load triangle makes 3 reads, uses the shared multiplier, adds its edges.
// A fetch reads the edge count of each vertex passed and each of its slots, and for a facing slot
// scans the reverse vertex's edges; an exhausted walk ends with a not-found result.
// Each result shows for one cycle on rsp_valid in the first idle cycle; the receiver cannot stall.
// Reset and begin surface run a clearing pass that zeroes all MAX_VERTICES edge counts.
module silhouette_edge_finder #(
   parameter int MAX_VERTICES     = 1024,
   parameter int EDGES_PER_VERTEX = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [9:0]  req_index_a,
   input  logic [9:0]  req_index_b,
   input  logic [9:0]  req_index_c,
   input  logic signed [15:0] req_coord_x,
   input  logic signed [15:0] req_coord_y,
   input  logic signed [15:0] req_coord_z,
   output logic        rsp_valid,
   output logic        rsp_edge_found,
   output logic [9:0]  rsp_edge_from,
   output logic [9:0]  rsp_edge_to,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int SW = $clog2(EDGES_PER_VERTEX);
   localparam int CW = $clog2(EDGES_PER_VERTEX + 1);
   localparam int ED = MAX_VERTICES << SW;
   localparam logic [VW-1:0] LAST_V = VW'(MAX_VERTICES - 1);
   localparam logic [CW-1:0] EPV    = CW'(EDGES_PER_VERTEX);

   // Memories.
   logic [3*sef_pkg::COORD_W-1:0] vert_mem [MAX_VERTICES];
   logic [VW:0]                   edge_mem [ED];
   logic [CW-1:0]                 cnt_mem  [MAX_VERTICES];

   // Configuration registers.
   logic signed [15:0] light_x_ff, light_y_ff, light_z_ff;
   logic [10:0]        vcount_ff;

   // Sequencer registers.
   sef_pkg::state_type state_ff, state_in;
   logic [VW-1:0] clr_ff, clr_in;
   logic [VW-1:0] ia_ff, ib_ff, ic_ff;
   logic [VW-1:0] ia_in, ib_in, ic_in;
   logic signed [15:0] vax_ff, vay_ff, vaz_ff, vax_in, vay_in, vaz_in;
   logic signed [16:0] d1x_ff, d1y_ff, d1z_ff, d2x_ff, d2y_ff, d2z_ff;
   logic signed [16:0] d1x_in, d1y_in, d1z_in, d2x_in, d2y_in, d2z_in;
   logic [3:0] k_ff, k_in;
   logic signed [sef_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [sef_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic signed [sef_pkg::NORM_W-1:0] nx_ff, ny_ff, nz_ff, nx_in, ny_in, nz_in;
   logic face_ff, face_in;
   logic [1:0] e_ff, e_in;
   logic [VW:0] walk_v_ff, walk_v_in;
   logic [CW-1:0] walk_s_ff, walk_s_in;
   logic [VW-1:0] eto_ff, eto_in;
   logic [CW-1:0] cnt_t_ff, cnt_t_in, scan_ff, scan_in;
   logic pend_ff, pend_in;
   logic rsp_valid_ff, rsp_valid_in, found_ff, found_in;
   logic [9:0] from_ff, from_in, to_ff, to_in;

   // Memory port signals.
   logic [VW-1:0] vaddr;
   logic [3*sef_pkg::COORD_W-1:0] vrd_ff;
   logic          vwe;
   logic [VW-1:0] caddr, cwaddr;
   logic [CW-1:0] crd_ff, cwdata;
   logic          cwe;
   logic [VW+SW-1:0] eaddr, ewaddr;
   logic [VW:0]   erd_ff, ewdata;
   logic          ewe;

   // Helper values.
   logic [12:0] a13, b13, c13, wv13, to13;
   logic        tri_ok, vert_ok;
   logic [13:0] limit;
   logic signed [15:0] vrx, vry, vrz;
   logic signed [sef_pkg::NORM_W-1:0] op_a;
   logic signed [16:0] op_b;
   logic signed [sef_pkg::ACC_W-1:0] sum;
   logic [VW-1:0] e_from, e_to;
   logic hit;

   assign a13     = 13'(req_index_a);
   assign b13     = 13'(req_index_b);
   assign c13     = 13'(req_index_c);
   assign vert_ok = a13 < 13'(MAX_VERTICES);
   assign tri_ok  = vert_ok && (b13 < 13'(MAX_VERTICES)) && (c13 < 13'(MAX_VERTICES));
   assign limit   = (14'(vcount_ff) < 14'(MAX_VERTICES)) ? 14'(vcount_ff) : 14'(MAX_VERTICES);
   assign wv13    = 13'(walk_v_ff);
   assign to13    = 13'(eto_ff);
   assign vrx     = $signed(vrd_ff[47:32]);
   assign vry     = $signed(vrd_ff[31:16]);
   assign vrz     = $signed(vrd_ff[15:0]);

   // Vertex store: one write, one registered read.
   always_ff @(posedge clock) begin
      if (vwe) begin
         vert_mem[vaddr] <= {req_coord_x, req_coord_y, req_coord_z};
      end
      vrd_ff <= vert_mem[vaddr];
   end

   // Edge count store.
   always_ff @(posedge clock) begin
      if (cwe) begin
         cnt_mem[cwaddr] <= cwdata;
      end
      crd_ff <= cnt_mem[caddr];
   end

   // Edge store: face bit above the end vertex.
   always_ff @(posedge clock) begin
      if (ewe) begin
         edge_mem[ewaddr] <= ewdata;
      end
      erd_ff <= edge_mem[eaddr];
   end

   // Configuration writes.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         light_x_ff <= '0;
         light_y_ff <= '0;
         light_z_ff <= '0;
         vcount_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            sef_pkg::CSR_LIGHT_X:      light_x_ff <= $signed(csr_wdata);
            sef_pkg::CSR_LIGHT_Y:      light_y_ff <= $signed(csr_wdata);
            sef_pkg::CSR_LIGHT_Z:      light_z_ff <= $signed(csr_wdata);
            sef_pkg::CSR_VERTEX_COUNT: vcount_ff  <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   // Shared multiplier operand selection.
   always_comb begin
      case (k_ff)
         4'd0:    begin op_a = sef_pkg::NORM_W'(d1y_ff); op_b = d2z_ff; end
         4'd1:    begin op_a = sef_pkg::NORM_W'(d1z_ff); op_b = d2y_ff; end
         4'd2:    begin op_a = sef_pkg::NORM_W'(d1z_ff); op_b = d2x_ff; end
         4'd3:    begin op_a = sef_pkg::NORM_W'(d1x_ff); op_b = d2z_ff; end
         4'd4:    begin op_a = sef_pkg::NORM_W'(d1x_ff); op_b = d2y_ff; end
         4'd5:    begin op_a = sef_pkg::NORM_W'(d1y_ff); op_b = d2x_ff; end
         4'd6:    begin op_a = nx_ff; op_b = 17'(light_x_ff); end
         4'd7:    begin op_a = ny_ff; op_b = 17'(light_y_ff); end
         default: begin op_a = nz_ff; op_b = 17'(light_z_ff); end
      endcase
   end

   // Cross products subtract on odd steps.
   assign sum = (k_ff < sef_pkg::DOT_STEP && k_ff[0]) ?
                acc_ff - sef_pkg::ACC_W'(prod_ff) : acc_ff + sef_pkg::ACC_W'(prod_ff);

   // Directed edges of the triangle: a->b, b->c, c->a.
   always_comb begin
      case (e_ff)
         2'd0:    begin e_from = ia_ff; e_to = ib_ff; end
         2'd1:    begin e_from = ib_ff; e_to = ic_ff; end
         default: begin e_from = ic_ff; e_to = ia_ff; end
      endcase
   end

   assign hit = pend_ff && erd_ff[VW] && (erd_ff[VW-1:0] == walk_v_ff[VW-1:0]);

   // Sequencer next state and memory controls.
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      ia_in = ia_ff; ib_in = ib_ff; ic_in = ic_ff;
      vax_in = vax_ff; vay_in = vay_ff; vaz_in = vaz_ff;
      d1x_in = d1x_ff; d1y_in = d1y_ff; d1z_in = d1z_ff;
      d2x_in = d2x_ff; d2y_in = d2y_ff; d2z_in = d2z_ff;
      k_in = k_ff; prod_in = prod_ff; acc_in = acc_ff;
      nx_in = nx_ff; ny_in = ny_ff; nz_in = nz_ff;
      face_in = face_ff; e_in = e_ff;
      walk_v_in = walk_v_ff; walk_s_in = walk_s_ff;
      eto_in = eto_ff; cnt_t_in = cnt_t_ff; scan_in = scan_ff; pend_in = pend_ff;
      rsp_valid_in = 1'b0; found_in = found_ff; from_in = from_ff; to_in = to_ff;
      vaddr = a13[VW-1:0]; vwe = 1'b0;
      caddr = walk_v_ff[VW-1:0]; cwaddr = clr_ff; cwdata = '0; cwe = 1'b0;
      eaddr = {walk_v_ff[VW-1:0], walk_s_ff[SW-1:0]};
      ewaddr = {e_from, crd_ff[SW-1:0]}; ewdata = {face_ff, e_to}; ewe = 1'b0;
      unique case (state_ff)
         sef_pkg::ST_CLEAR: begin
            cwe = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_V) begin
               state_in = sef_pkg::ST_IDLE;
            end
         end
         sef_pkg::ST_IDLE: begin
            if (start) begin
               case (sef_pkg::op_type'(req_op))
                  sef_pkg::OP_BEGIN: begin
                     walk_v_in = '0;
                     walk_s_in = '0;
                     clr_in = '0;
                     state_in = sef_pkg::ST_CLEAR;
                  end
                  sef_pkg::OP_VERTEX: begin
                     vwe = vert_ok;
                  end
                  sef_pkg::OP_TRIANGLE: begin
                     ia_in = a13[VW-1:0];
                     ib_in = b13[VW-1:0];
                     ic_in = c13[VW-1:0];
                     if (tri_ok) begin
                        state_in = sef_pkg::ST_VRD_B;
                     end
                  end
                  default: begin
                     state_in = sef_pkg::ST_WCHK;
                  end
               endcase
            end
         end
         sef_pkg::ST_VRD_B: begin
            vax_in = vrx; vay_in = vry; vaz_in = vrz;
            vaddr = ib_ff;
            state_in = sef_pkg::ST_VRD_C;
         end
         sef_pkg::ST_VRD_C: begin
            // B is in the read register while C is being read.
            d1x_in = 17'(vrx) - 17'(vax_ff);
            d1y_in = 17'(vry) - 17'(vay_ff);
            d1z_in = 17'(vrz) - 17'(vaz_ff);
            vaddr = ic_ff;
            state_in = sef_pkg::ST_VCAP_C;
         end
         sef_pkg::ST_VCAP_C: begin
            // C is in the read register.
            d2x_in = 17'(vrx) - 17'(vax_ff);
            d2y_in = 17'(vry) - 17'(vay_ff);
            d2z_in = 17'(vrz) - 17'(vaz_ff);
            state_in = sef_pkg::ST_MUL;
            k_in = '0;
            acc_in = '0;
         end
         sef_pkg::ST_MUL: begin
            prod_in = op_a * op_b;
            state_in = sef_pkg::ST_ACC;
         end
         sef_pkg::ST_ACC: begin
            k_in = k_ff + 1'b1;
            state_in = sef_pkg::ST_MUL;
            if (k_ff < sef_pkg::DOT_STEP && k_ff[0]) begin
               acc_in = '0;
               case (k_ff)
                  4'd1:    nx_in = sum[sef_pkg::NORM_W-1:0];
                  4'd3:    ny_in = sum[sef_pkg::NORM_W-1:0];
                  default: nz_in = sum[sef_pkg::NORM_W-1:0];
               endcase
            end else begin
               acc_in = sum;
            end
            if (k_ff == sef_pkg::LAST_STEP) begin
               face_in = sum > 0;
               e_in = '0;
               state_in = sef_pkg::ST_ECNT_RD;
            end
         end
         sef_pkg::ST_ECNT_RD: begin
            caddr = e_from;
            state_in = sef_pkg::ST_ECNT_WR;
         end
         sef_pkg::ST_ECNT_WR: begin
            if (crd_ff < EPV) begin
               ewe = 1'b1;
               cwe = 1'b1;
               cwaddr = e_from;
               cwdata = crd_ff + 1'b1;
            end
            e_in = e_ff + 1'b1;
            state_in = (e_ff == 2'd2) ? sef_pkg::ST_IDLE : sef_pkg::ST_ECNT_RD;
         end
         sef_pkg::ST_WCHK: begin
            if (14'(walk_v_ff) >= limit) begin
               rsp_valid_in = 1'b1;
               found_in = 1'b0;
               from_in = '0;
               to_in = '0;
               state_in = sef_pkg::ST_IDLE;
            end else begin
               state_in = sef_pkg::ST_WCNT;
            end
         end
         sef_pkg::ST_WCNT: begin
            if (walk_s_ff < crd_ff) begin
               walk_s_in = walk_s_ff + 1'b1;
               state_in = sef_pkg::ST_WSLOT;
            end else begin
               walk_v_in = walk_v_ff + 1'b1;
               walk_s_in = '0;
               state_in = sef_pkg::ST_WCHK;
            end
         end
         sef_pkg::ST_WSLOT: begin
            eto_in = erd_ff[VW-1:0];
            caddr = erd_ff[VW-1:0];
            state_in = erd_ff[VW] ? sef_pkg::ST_RCNT : sef_pkg::ST_WCHK;
         end
         sef_pkg::ST_RCNT: begin
            cnt_t_in = crd_ff;
            scan_in = '0;
            pend_in = 1'b0;
            state_in = sef_pkg::ST_RSCAN;
         end
         sef_pkg::ST_RSCAN: begin
            // Reads are issued every cycle and each is checked in the cycle after it is issued.
            eaddr = {eto_ff, scan_ff[SW-1:0]};
            if (hit) begin
               pend_in = 1'b0;
               state_in = sef_pkg::ST_WCHK;
            end else if (scan_ff < cnt_t_ff) begin
               scan_in = scan_ff + 1'b1;
               pend_in = 1'b1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               rsp_valid_in = 1'b1;
               found_in = 1'b1;
               from_in = wv13[9:0];
               to_in = to13[9:0];
               state_in = sef_pkg::ST_IDLE;
            end
         end
         default: state_in = sef_pkg::ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sef_pkg::ST_CLEAR;
         clr_ff       <= '0;
         walk_v_ff    <= '0;
         walk_s_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         walk_v_ff    <= walk_v_in;
         walk_s_ff    <= walk_s_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      ia_ff <= ia_in; ib_ff <= ib_in; ic_ff <= ic_in;
      vax_ff <= vax_in; vay_ff <= vay_in; vaz_ff <= vaz_in;
      d1x_ff <= d1x_in; d1y_ff <= d1y_in; d1z_ff <= d1z_in;
      d2x_ff <= d2x_in; d2y_ff <= d2y_in; d2z_ff <= d2z_in;
      k_ff <= k_in; prod_ff <= prod_in; acc_ff <= acc_in;
      nx_ff <= nx_in; ny_ff <= ny_in; nz_ff <= nz_in;
      face_ff <= face_in; e_ff <= e_in;
      eto_ff <= eto_in; cnt_t_ff <= cnt_t_in; scan_ff <= scan_in;
      found_ff <= found_in; from_ff <= from_in; to_ff <= to_in;
   end

   assign busy           = state_ff != sef_pkg::ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_found = found_ff;
   assign rsp_edge_from  = from_ff;
   assign rsp_edge_to    = to_ff;

   // A result strobe lasts one cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");

   // A result is shown only once the sequencer is back in idle.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");

   // A fetch always makes the block busy on the next cycle.
   a_fetch_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op == sef_pkg::OP_FETCH) |=> busy)
      else $error("fetch not started");

   // The clearing pass gives no result.
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sef_pkg::ST_CLEAR) |-> !rsp_valid) else $error("result during clear");

endmodule

/* tb/silhouette_edge_finder_tb.sv */
// Self-checking testbench for the silhouette edge finder.
module silhouette_edge_finder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NVERT = 1024;
   localparam int NSLOT = 32;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_op = 2'd0;
   logic [9:0] req_index_a = '0, req_index_b = '0, req_index_c = '0;
   logic signed [15:0] req_coord_x = '0, req_coord_y = '0, req_coord_z = '0;
   logic rsp_valid, rsp_edge_found;
   logic [9:0] rsp_edge_from, rsp_edge_to;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   silhouette_edge_finder uut (.*);

   always #5 clock = ~clock;

   // Predicted edge results, oldest first.
   typedef struct packed {
      logic       found;
      logic [9:0] from_v;
      logic [9:0] to_v;
   } edge_rec_type;
   edge_rec_type pending_edges[$];

   // Shadow copy of the block state.
   logic signed [15:0] lx, ly, lz;
   logic [10:0] vcount;
   logic signed [15:0] px[NVERT], py[NVERT], pz[NVERT];
   logic        loaded[NVERT];
   logic [9:0]  etab_to[NVERT][NSLOT];
   logic        etab_face[NVERT][NSLOT];
   logic [5:0]  ecnt[NVERT];
   int unsigned walk_v, walk_s;
   int errors = 0;

   // Result checker: every strobe is compared with the oldest prediction.
   always @(posedge clock) begin
      edge_rec_type e;
      if (!reset && rsp_valid) begin
         if (pending_edges.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %b %0d %0d",
               rsp_edge_found, rsp_edge_from, rsp_edge_to);
         end else begin
            e = pending_edges.pop_front();
            if (e.found !== rsp_edge_found || e.from_v !== rsp_edge_from ||
                e.to_v !== rsp_edge_to) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch exp %b %0d->%0d got %b %0d->%0d", e.found,
                     e.from_v, e.to_v, rsp_edge_found, rsp_edge_from, rsp_edge_to);
            end
         end
      end
   end

   function automatic void add_edge(int unsigned f, int unsigned t, logic face);
      if (ecnt[f] < NSLOT) begin
         etab_to[f][ecnt[f]] = t[9:0];
         etab_face[f][ecnt[f]] = face;
         ecnt[f] = ecnt[f] + 6'd1;
      end
   endfunction

   function automatic logic facing_reverse(int unsigned f, int unsigned t);
      for (int k = 0; k < ecnt[t]; k++)
         if (etab_to[t][k] == f && etab_face[t][k]) return 1'b1;
      return 1'b0;
   endfunction

   // Predict the effect of one accepted item.
   function automatic void predict_item(logic [1:0] op, int unsigned a, int unsigned b,
                                        int unsigned c, logic signed [15:0] x,
                                        logic signed [15:0] y, logic signed [15:0] z);
      longint d1x, d1y, d1z, d2x, d2y, d2z, nx, ny, nz, dot;
      int unsigned lim, to;
      logic face;
      edge_rec_type r;
      case (sef_pkg::op_type'(op))
         sef_pkg::OP_BEGIN: begin
            for (int i = 0; i < NVERT; i++) ecnt[i] = 0;
            walk_v = 0; walk_s = 0;
         end
         sef_pkg::OP_VERTEX: begin
            px[a] = x; py[a] = y; pz[a] = z; loaded[a] = 1'b1;
         end
         sef_pkg::OP_TRIANGLE: begin
            d1x = px[b] - px[a]; d1y = py[b] - py[a]; d1z = pz[b] - pz[a];
            d2x = px[c] - px[a]; d2y = py[c] - py[a]; d2z = pz[c] - pz[a];
            nx = d1y * d2z - d1z * d2y;
            ny = d1z * d2x - d1x * d2z;
            nz = d1x * d2y - d1y * d2x;
            dot = nx * lx + ny * ly + nz * lz;
            face = dot > 0;
            add_edge(a, b, face);
            add_edge(b, c, face);
            add_edge(c, a, face);
         end
         default: begin
            lim = vcount < NVERT ? vcount : NVERT;
            r = '0;
            while (walk_v < lim && !r.found) begin
               while (walk_s < ecnt[walk_v] && !r.found) begin
                  to = etab_to[walk_v][walk_s];
                  if (etab_face[walk_v][walk_s] && !facing_reverse(walk_v, to))
                     r = '{1'b1, walk_v[9:0], to[9:0]};
                  walk_s++;
               end
               if (!r.found) begin
                  walk_v++; walk_s = 0;
               end
            end
            pending_edges.push_back(r);
         end
      endcase
   endfunction

   // Send one item after a random gap, then wait for acceptance.
   // Start stays high after acceptance so that a following item can go with no gap.
   task automatic send_item(logic [1:0] op, int unsigned a, int unsigned b = 0,
                            int unsigned c = 0, logic signed [15:0] x = 0,
                            logic signed [15:0] y = 0, logic signed [15:0] z = 0);
      int unsigned gap;
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_op <= op; req_index_a <= a[9:0]; req_index_b <= b[9:0]; req_index_c <= c[9:0];
      req_coord_x <= x; req_coord_y <= y; req_coord_z <= z;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      predict_item(op, a, b, c, x, y, z);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_edges.size() != 0) @(posedge clock);
      do @(posedge clock); while (busy);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] val);
      csr_index <= idx; csr_wdata <= val; csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         sef_pkg::CSR_LIGHT_X: lx = val;
         sef_pkg::CSR_LIGHT_Y: ly = val;
         sef_pkg::CSR_LIGHT_Z: lz = val;
         default: vcount = val[10:0];
      endcase
      @(posedge clock);
   endtask

   task automatic set_light(int x, int y, int z, int n);
      wait_idle();
      write_csr(sef_pkg::CSR_LIGHT_X, x[15:0]);
      write_csr(sef_pkg::CSR_LIGHT_Y, y[15:0]);
      write_csr(sef_pkg::CSR_LIGHT_Z, z[15:0]);
      write_csr(sef_pkg::CSR_VERTEX_COUNT, n[15:0]);
   endtask

   // A closed tetrahedron at the coordinate extremes, then a repeated triangle and vertex count changes.
   task automatic test_directed();
      set_light(16384, 0, 0, 1024);
      send_item(sef_pkg::OP_BEGIN, 0);
      send_item(sef_pkg::OP_VERTEX, 0, 0, 0, -32768, -32768, -32768);
      send_item(sef_pkg::OP_VERTEX, 1, 0, 0, 32767, -32768, -32768);
      send_item(sef_pkg::OP_VERTEX, 2, 0, 0, -32768, 32767, -32768);
      send_item(sef_pkg::OP_VERTEX, 1023, 0, 0, -32768, -32768, 32767);
      send_item(sef_pkg::OP_TRIANGLE, 0, 2, 1);
      send_item(sef_pkg::OP_TRIANGLE, 0, 1, 1023);
      send_item(sef_pkg::OP_TRIANGLE, 0, 1023, 2);
      send_item(sef_pkg::OP_TRIANGLE, 1, 2, 1023);
      repeat (6) send_item(sef_pkg::OP_FETCH, 0);
      // Full edge list: many triangles sharing vertex 0.
      set_light(-16384, 16384, -16384, 4);
      send_item(sef_pkg::OP_BEGIN, 0);
      repeat (35) send_item(sef_pkg::OP_TRIANGLE, 0, 1, 2);
      // Vertex count change during a walk.
      send_item(sef_pkg::OP_FETCH, 0);
      wait_idle();
      write_csr(sef_pkg::CSR_VERTEX_COUNT, 16'd0);
      send_item(sef_pkg::OP_FETCH, 0);
      wait_idle();
      write_csr(sef_pkg::CSR_VERTEX_COUNT, 16'd2047);
      repeat (3) send_item(sef_pkg::OP_FETCH, 0);
   endtask

   // Random surfaces on a small vertex set, mostly well-formed.
   task automatic test_random(int items);
      int unsigned a, b, c, r, nv;
      int done = 0;
      nv = 16;
      while (done < items) begin
         // The first pass always builds a fresh surface so every vertex used is loaded.
         if (done == 0 || $urandom_range(0, 99) < 4) begin
            set_light($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                      $urandom_range(0, 32768) - 16384,
                      $urandom_range(0, 3) == 0 ? 2047 : $urandom_range(0, nv + 2));
            send_item(sef_pkg::OP_BEGIN, 0);
            for (int i = 0; i < nv; i++)
               send_item(sef_pkg::OP_VERTEX, i, $urandom, $urandom, 16'($urandom),
                         16'($urandom), 16'($urandom));
            done += nv + 1;
         end
         r = $urandom_range(0, 99);
         a = $urandom_range(0, nv - 1); b = $urandom_range(0, nv - 1);
         c = $urandom_range(0, nv - 1);
         if (r < 45) send_item(sef_pkg::OP_TRIANGLE, a, b, c);
         else if (r < 85) send_item(sef_pkg::OP_FETCH, $urandom, $urandom, $urandom);
         else if (r < 95) send_item(sef_pkg::OP_VERTEX, a, $urandom, $urandom,
                                    16'($urandom), 16'($urandom), 16'($urandom));
         else if (r < 97) begin
            // Stray high vertex, loaded before being used.
            a = 1000 + $urandom_range(0, 23);
            send_item(sef_pkg::OP_VERTEX, a, 0, 0, 16'($urandom), 16'($urandom),
                      16'($urandom));
            send_item(sef_pkg::OP_TRIANGLE, a, b, c);
         end else send_item(sef_pkg::OP_BEGIN, $urandom);
         if (r == 50) wait_idle();
         done++;
      end
   endtask

   initial begin
      for (int i = 0; i < NVERT; i++) begin
         ecnt[i] = 0; loaded[i] = 0; px[i] = 0; py[i] = 0; pz[i] = 0;
      end
      lx = 0; ly = 0; lz = 0; vcount = 0; walk_v = 0; walk_s = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(450);
      wait_idle();
      if (errors == 0 && pending_edges.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      #50ms;
      $display("TB_ERROR");
      $finish;
   end
endmodule

/* sim.f */
rtl/sef_pkg.sv
rtl/silhouette_edge_finder.sv
tb/silhouette_edge_finder_tb.sv
